/* rtl/core/hsrl_pkg.sv */
// Shared types and constants for the selective-repeat handshake link.
package hsrl_pkg;
   localparam int Window = 4;
   localparam int SlotW = $clog2(Window);
   localparam int UsedW = $clog2(Window + 1);
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      OP_FIN = 3'd0, OP_SYN = 3'd1, OP_ACK = 3'd2, OP_DATA = 3'd3,
      OP_CONNECT = 3'd4, OP_CLOSE = 3'd5, OP_SEND = 3'd6, OP_TIMEOUT = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_WAIT = 2'd0, ST_SYN_SENT = 2'd1, ST_SYN_RCVD = 2'd2, ST_CONN = 2'd3
   } conn_type;

   localparam logic [1:0] PK_FIN = 2'd0, PK_SYN = 2'd1, PK_ACK = 2'd2, PK_DATA = 2'd3;
   localparam logic [1:0] KIND_STATUS = 2'd0, KIND_TX = 2'd1, KIND_DELIVER = 2'd2;
   localparam logic [1:0] TMR_NONE = 2'd0, TMR_START = 2'd1, TMR_STOP = 2'd2;

   // Input item as held in the front-to-back queue.
   typedef struct packed {
      op_type      op;
      logic [31:0] pkt_seq;
      logic [31:0] pkt_ack;
      logic [63:0] payload;
   } event_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  tx_type;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack;
      logic [63:0] data_word;
      logic [1:0]  timer_cmd;
      logic [1:0]  state_now;
      logic        window_full;
      logic        last;
   } result_type;

   // Back-end sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE, PH_EMIT1, PH_EMIT2, PH_SLIDE, PH_DELIVER
   } phase_type;
endpackage

/* rtl/core/hsrl_front.sv */
// Front end: accepts event items into a short queue.
module hsrl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsrl_pkg::event_type  in_item,
   output logic                 q_valid,
   input  logic                 q_ready,
   output hsrl_pkg::event_type  q_item
);
   import hsrl_pkg::*;

   event_type              mem_ff [QueueDepth];
   logic [$clog2(QueueDepth)-1:0] wp_ff, rp_ff;
   logic [$clog2(QueueDepth+1)-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != QueueDepth[$clog2(QueueDepth+1)-1:0]);
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/core/hsrl_back.sv */
// Back end: connection machine, send/receive windows and result sequencing.
module hsrl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  hsrl_pkg::event_type  q_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsrl_pkg::result_type out_item
);
   import hsrl_pkg::*;

   phase_type   ph_ff, ph_in;
   conn_type    st_ff, st_in;
   event_type   ev_ff, ev_in;
   logic [31:0] sbase_ff, sbase_in, snext_ff, snext_in;
   logic [31:0] rbase_ff, rbase_in, rlim_ff, rlim_in;
   logic [UsedW-1:0] used_ff, used_in;
   logic [Window-1:0] arr_ff, arr_in, ackm_ff, ackm_in;
   logic [SlotW:0] cnt_ff, cnt_in;
   logic [63:0] ostore [Window];
   logic [63:0] istore [Window];
   logic        ow_en, iw_en;
   logic [SlotW-1:0] ow_a, iw_a;
   result_type  res_ff, res_in;
   logic        rv_ff, rv_in;
   result_type  r;
   logic        emit, take;
   logic [SlotW-1:0] sb_slot, rb_slot;
   logic [31:0] dseq, dack, back;

   assign out_valid = rv_ff;
   assign out_item  = res_ff;
   assign take = !rv_ff || out_ready;
   assign q_ready = (ph_ff == PH_IDLE) && take;
   assign sb_slot = sbase_ff[SlotW-1:0];
   assign rb_slot = rbase_ff[SlotW-1:0];

   // Event sequencing: one result item per cycle at most
   always_comb begin
      ph_in = ph_ff; st_in = st_ff; ev_in = ev_ff;
      sbase_in = sbase_ff; snext_in = snext_ff; rbase_in = rbase_ff; rlim_in = rlim_ff;
      used_in = used_ff; arr_in = arr_ff; ackm_in = ackm_ff; cnt_in = cnt_ff;
      ow_en = 1'b0; iw_en = 1'b0; ow_a = '0; iw_a = '0;
      r = '0; emit = 1'b0;
      rv_in = rv_ff && !out_ready;
      res_in = res_ff;
      dseq = ev_ff.pkt_seq - rbase_ff;
      dack = ev_ff.pkt_ack - sbase_ff;
      back = rbase_ff - ev_ff.pkt_seq;
      unique case (ph_ff)
         PH_IDLE: begin
            if (q_valid && take) begin
               ev_in = q_item;
               ph_in = PH_EMIT1;
            end
         end
         PH_EMIT1: begin
            if (take) begin
               emit = 1'b1; r.last = 1'b1; ph_in = PH_IDLE;
               unique case (st_ff)
                  ST_WAIT: begin
                     if (ev_ff.op == OP_SYN) begin
                        r.kind = KIND_TX; r.tx_type = PK_ACK; r.tx_ack = ev_ff.pkt_seq;
                        r.last = 1'b0; ph_in = PH_EMIT2; st_in = ST_SYN_RCVD;
                     end else if (ev_ff.op == OP_CONNECT) begin
                        r.kind = KIND_TX; r.tx_type = PK_SYN; r.tx_seq = sbase_ff;
                        r.timer_cmd = TMR_START; st_in = ST_SYN_SENT;
                     end
                  end
                  ST_SYN_SENT, ST_SYN_RCVD: begin
                     case (ev_ff.op)
                        OP_FIN, OP_CLOSE: begin
                           r.kind = KIND_TX; r.tx_type = PK_FIN; st_in = ST_WAIT;
                        end
                        OP_SYN: begin
                           r.kind = KIND_TX; r.tx_type = PK_ACK; r.tx_ack = ev_ff.pkt_seq;
                           r.last = 1'b0; ph_in = PH_EMIT2; st_in = ST_SYN_RCVD;
                        end
                        OP_ACK: begin
                           r.timer_cmd = TMR_STOP; st_in = ST_CONN;
                        end
                        OP_TIMEOUT: begin
                           r.kind = KIND_TX; r.tx_type = PK_SYN; r.tx_seq = sbase_ff;
                           r.timer_cmd = TMR_START;
                        end
                        default: ;
                     endcase
                  end
                  ST_CONN: begin
                     case (ev_ff.op)
                        OP_FIN, OP_CLOSE: begin
                           r.kind = KIND_TX; r.tx_type = PK_FIN; st_in = ST_WAIT;
                        end
                        OP_SYN: begin
                           r.kind = KIND_TX; r.tx_type = PK_ACK; r.tx_ack = ev_ff.pkt_seq;
                        end
                        OP_ACK: begin
                           emit = 1'b0;
                           if (dack < (snext_ff - sbase_ff)) begin
                              ackm_in[ev_ff.pkt_ack[SlotW-1:0]] = 1'b1;
                              cnt_in = '0; ph_in = PH_SLIDE;
                           end else begin
                              emit = 1'b1;
                           end
                        end
                        OP_DATA: begin
                           if (dseq < (rlim_ff - rbase_ff)) begin
                              arr_in[ev_ff.pkt_seq[SlotW-1:0]] = 1'b1;
                              iw_en = 1'b1; iw_a = ev_ff.pkt_seq[SlotW-1:0];
                              r.kind = KIND_TX; r.tx_type = PK_ACK; r.tx_ack = ev_ff.pkt_seq;
                              // deliveries follow only once the base slot has arrived
                              if (arr_in[rb_slot]) begin
                                 r.last = 1'b0; cnt_in = '0; ph_in = PH_DELIVER;
                              end
                           end else if (back >= 32'd1 && back <= 32'h8000_0000) begin
                              r.kind = KIND_TX; r.tx_type = PK_ACK; r.tx_ack = ev_ff.pkt_seq;
                           end
                        end
                        OP_SEND: begin
                           r.timer_cmd = (used_ff == '0) ? TMR_START : TMR_NONE;
                           if (used_ff < UsedW'(Window)) begin
                              r.kind = KIND_TX; r.tx_type = PK_DATA; r.tx_seq = snext_ff;
                              r.data_word = ev_ff.payload;
                              ow_en = 1'b1; ow_a = snext_ff[SlotW-1:0];
                              snext_in = snext_ff + 32'd1; used_in = used_ff + 1'b1;
                           end else begin
                              r.window_full = 1'b1;
                           end
                        end
                        OP_TIMEOUT: begin
                           if (used_ff != '0) begin
                              r.kind = KIND_TX; r.tx_type = PK_DATA; r.tx_seq = sbase_ff;
                              r.data_word = ostore[sb_slot]; r.timer_cmd = TMR_START;
                           end
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
               r.state_now = st_in;
            end
         end
         PH_EMIT2: begin
            if (take) begin
               emit = 1'b1; r.kind = KIND_TX; r.tx_type = PK_SYN; r.tx_seq = sbase_ff;
               r.timer_cmd = TMR_START; r.last = 1'b1; r.state_now = st_ff;
               ph_in = PH_IDLE;
            end
         end
         PH_SLIDE: begin
            // Release acked slots in order, one per cycle
            if (ackm_ff[sb_slot] && cnt_ff != (SlotW+1)'(Window)) begin
               ackm_in[sb_slot] = 1'b0;
               if (used_ff != '0) used_in = used_ff - 1'b1;
               sbase_in = sbase_ff + 32'd1;
               cnt_in = cnt_ff + 1'b1;
            end else if (take) begin
               emit = 1'b1; r.last = 1'b1; r.state_now = st_ff; ph_in = PH_IDLE;
            end
         end
         PH_DELIVER: begin
            // Deliver consecutive arrived words, one per cycle while the output takes them
            if (take) begin
               emit = 1'b1; r.kind = KIND_DELIVER; r.data_word = istore[rb_slot];
               r.state_now = st_ff;
               arr_in[rb_slot] = 1'b0;
               rbase_in = rbase_ff + 32'd1; rlim_in = rlim_ff + 32'd1;
               cnt_in = cnt_ff + 1'b1;
               if (!(arr_ff[rbase_in[SlotW-1:0]]) || cnt_in == (SlotW+1)'(Window)) begin
                  r.last = 1'b1; ph_in = PH_IDLE;
               end
            end
         end
         default: ph_in = PH_IDLE;
      endcase
      if (emit) begin
         rv_in = 1'b1; res_in = r;
      end
   end

   // Window stores
   always_ff @(posedge clock) begin
      if (ow_en) ostore[ow_a] <= ev_ff.payload;
      if (iw_en) istore[iw_a] <= ev_ff.payload;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
      res_ff <= res_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; st_ff <= ST_WAIT;
         sbase_ff <= '0; snext_ff <= '0; rbase_ff <= '0; rlim_ff <= 32'(Window);
         used_ff <= '0; arr_ff <= '0; ackm_ff <= '0; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; st_ff <= st_in;
         sbase_ff <= sbase_in; snext_ff <= snext_in; rbase_ff <= rbase_in; rlim_ff <= rlim_in;
         used_ff <= used_in; arr_ff <= arr_in; ackm_ff <= ackm_in; cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
   end
endmodule

/* rtl/core/handshake_selective_repeat_link.sv */
// Top level of the selective-repeat handshake link.
// Usage:
//  - req_ channel takes one event item: a received FIN/SYN/ACK/DATA packet,
//    a user CONNECT/CLOSE/SEND or a retransmit TIMEOUT.
//  - rsp_ channel gives one to five result items per event (transmit packets,
//    timer commands, in-order deliveries); rsp_tlast marks the final one.
//  - A two-entry queue takes events while the back end works or the receiver
//    stalls; req_tready drops only when the queue is full.
//  - An event is captured from the queue into the back end; its first result item
//    is formed in PH_EMIT1 (PH_SLIDE for an in-window ACK) and then registered.
//  - The back end takes a new event only from its idle phase, once it has issued
//    all results of the previous one; an in-window ACK first releases up to 4
//    acked send slots in the sequencer, which walks window slots one a cycle.
//  - rsp_tvalid holds with stable data until rsp_tready; the sequencer waits.
//  - Reset (synchronous, active high) returns to waiting for connection with
//    empty windows; the word stores need no clearing.
module handshake_selective_repeat_link (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // pkt_seq[31:0], pkt_ack[63:32], payload[127:64]
   input  logic [2:0]    req_tuser,  // op
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,  // tx_seq, tx_ack, data_word, timer_cmd, state_now, window_full
   output logic [3:0]    rsp_tuser,  // kind[1:0], tx_type[3:2]
   output logic          rsp_tlast   // last
);
   import hsrl_pkg::*;

   event_type  in_item, q_item;
   result_type o;
   logic       q_valid, q_ready;

   assign in_item.op      = op_type'(req_tuser);
   assign in_item.pkt_seq = req_tdata[31:0];
   assign in_item.pkt_ack = req_tdata[63:32];
   assign in_item.payload = req_tdata[127:64];

   hsrl_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .q_valid, .q_ready, .q_item
   );

   hsrl_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(o)
   );

   // Pack result fields
   assign rsp_tdata = {3'd0, o.window_full, o.state_now, o.timer_cmd,
                       o.data_word, o.tx_ack, o.tx_seq};
   assign rsp_tuser = {o.tx_type, o.kind};
   assign rsp_tlast = o.last;
endmodule
